// ----- design/hamming_syndrome_decoder_defines.svh -----
// assertion macros used by the decoder rtl
`ifndef HAMMING_SYNDROME_DECODER_DEFINES_SVH
`define HAMMING_SYNDROME_DECODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define HSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsd: same-cycle check failed");
// next-cycle implication
`define HSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsd: next-cycle check failed");
`else
`define HSD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/hsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hsd_pkg;

    localparam int HSD_CODE_BITS = 7;
    localparam int HSD_DATA_BITS = 4;

    // p-th value from 1 upward that is not a power of two, zero if none up to code_bits
    function automatic int hsd_nonpow_value(input int p, input int code_bits);
        int count;
        int result;
        count  = 0;
        result = 0;
        for (int v = 1; v <= code_bits; v++) begin
            if ((v & (v - 1)) != 0) begin
                if (count == p && result == 0) begin
                    result = v;
                end
                count++;
            end
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ----- design/hsd_code_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hsd_code_if #(
    parameter int CODE_BITS = hsd_pkg::HSD_CODE_BITS
) ();
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] codeword;

    modport source (output valid, output codeword, input ready);
    modport sink   (input valid, input codeword, output ready);
endinterface

`default_nettype wire

// ----- design/hsd_data_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hsd_data_if #(
    parameter int DATA_BITS = hsd_pkg::HSD_DATA_BITS
) ();
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

`default_nettype wire

// ----- design/hsd_correct.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsd_correct #(
    parameter int CODE_BITS = hsd_pkg::HSD_CODE_BITS,
    parameter int DATA_BITS = hsd_pkg::HSD_DATA_BITS
) (
    input  logic [CODE_BITS-1:0] i_codeword,
    output logic [DATA_BITS-1:0] o_data_word
);
    import hsd_pkg::*;

    localparam int CHECK_BITS = CODE_BITS - DATA_BITS;
    localparam int SYN_W      = (CHECK_BITS > 0) ? CHECK_BITS : 1;

    logic [DATA_BITS-1:0] data_raw;

    // data bits beyond the codeword read as zero
    for (genvar p = 0; p < DATA_BITS; p++) begin : g_data
        if (p < CODE_BITS) begin : g_in
            assign data_raw[p] = i_codeword[p];
        end else begin : g_out
            assign data_raw[p] = 1'b0;
        end
    end

    if (CHECK_BITS > 0) begin : g_code
        logic [SYN_W-1:0]     data_term [DATA_BITS];
        logic [SYN_W-1:0]     check_term;
        logic [SYN_W-1:0]     syndrome;
        logic [DATA_BITS-1:0] flip;

        for (genvar p = 0; p < DATA_BITS; p++) begin : g_pos
            localparam int             RAW  = hsd_nonpow_value(p, CODE_BITS);
            localparam logic [SYN_W-1:0] VAL = SYN_W'(RAW);
            // position value must fit the syndrome to be correctable
            localparam bit             FITS = (RAW != 0) && ((RAW >> CHECK_BITS) == 0);

            assign data_term[p] = data_raw[p] ? VAL : '0;
            assign flip[p]      = FITS && (syndrome == VAL);
        end

        // first check bit carries the top syndrome bit
        for (genvar j = 0; j < CHECK_BITS; j++) begin : g_chk
            assign check_term[CHECK_BITS-1-j] = i_codeword[DATA_BITS+j];
        end

        always_comb begin
            syndrome = check_term;
            for (int p = 0; p < DATA_BITS; p++) begin
                syndrome = syndrome ^ data_term[p];
            end
        end

        assign o_data_word = data_raw ^ flip;
    end else begin : g_nocode
        assign o_data_word = data_raw;
    end

endmodule

`default_nettype wire

// ----- design/hamming_syndrome_decoder.sv -----
// hamming_syndrome_decoder: single-error-correcting hamming decoder
//
// input channel i_code carries one received codeword per transfer, data
// bits in the low positions and check bits above them. output channel
// o_data carries the corrected data word, one transfer per codeword, in
// order. both channels use valid/ready; a transfer happens on a rising
// edge with valid and ready high.
//
// the codeword is captured in an input register, and the syndrome xor
// tree and position decode sit between that and the result register.
// throughput is one codeword per cycle while o_data.ready stays high,
// set by the two register stages each advancing every cycle.
//
// when the receiver stalls the result register holds its word and the
// input register fills behind it; i_code.ready drops only once both are
// occupied. synchronous active-low reset empties both stages; there is no
// other state.
`timescale 1ns / 1ps
`default_nettype none

module hamming_syndrome_decoder #(
    parameter int CODE_BITS = hsd_pkg::HSD_CODE_BITS,
    parameter int DATA_BITS = hsd_pkg::HSD_DATA_BITS
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    hsd_code_if.sink      i_code,
    hsd_data_if.source    o_data
);
    import hsd_pkg::*;

`include "hamming_syndrome_decoder_defines.svh"

    // stage 1: captured codeword
    logic                 r_s1_valid;
    logic [CODE_BITS-1:0] r_codeword;
    // stage 2: corrected result waiting for its transfer
    logic                 r_s2_valid;
    logic [DATA_BITS-1:0] r_data_word;

    logic                 w_s1_ready;
    logic                 w_s2_ready;
    logic                 w_s1_move;
    logic [DATA_BITS-1:0] w_corrected;

    // a stage can take new data when empty or when its contents leave this cycle
    assign w_s2_ready = !r_s2_valid || o_data.ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    // stage 1 hands its codeword on to stage 2
    assign w_s1_move  = r_s1_valid && w_s2_ready;

    assign i_code.ready     = w_s1_ready;
    assign o_data.valid     = r_s2_valid;
    assign o_data.data_word = r_data_word;

    hsd_correct #(
        .CODE_BITS (CODE_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_correct (
        .i_codeword  (r_codeword),
        .o_data_word (w_corrected)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_code.valid;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_code.valid) begin
            r_codeword <= i_code.codeword;
        end
        if (w_s1_move) begin
            r_data_word <= w_corrected;
        end
    end

    // an empty result stage never back-pressures the input
    `HSD_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n, !r_s2_valid, i_code.ready)
    // accepted codeword lands in stage 1
    `HSD_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_code.valid && i_code.ready, r_s1_valid)
    // blocked stage 1 keeps its codeword
    `HSD_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, !w_s1_ready, r_s1_valid && $stable(r_codeword))
    // advancing codeword fills the result stage
    `HSD_ASSERT_NEXT(a_s2_fills, i_clk, i_rst_n, w_s1_move, r_s2_valid)
    // and the result stage holds its corrected word
    `HSD_ASSERT_NEXT(a_s2_load, i_clk, i_rst_n, w_s1_move, r_data_word == $past(w_corrected))

endmodule

`default_nettype wire
